### hw/rtl/sdi_pkg.sv
// ----------------------------------------------------------------------------
// sdi_pkg
// Shared constants and types for the spring damping impulse pipeline.
// ----------------------------------------------------------------------------
package sdi_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // minimum-length register
   localparam int              MIN_LEN_W   = 16;
   localparam logic [15:0]     MIN_LEN_RST = 16'd1;

   // control bits that travel with every pipeline stage
   typedef struct packed {
      logic valid;
      logic a_mass;
      logic b_mass;
      logic skip;
   } stage_ctl_type;

endpackage

### hw/rtl/sdi_ifs.sv
// ----------------------------------------------------------------------------
// sdi channel interfaces
// Spring request, velocity response and min_length register write channels.
// ----------------------------------------------------------------------------
interface sdi_req_if #(parameter int DATA_WIDTH = sdi_pkg::DATA_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] pos_a_x;
   logic signed [DATA_WIDTH-1:0] pos_a_y;
   logic signed [DATA_WIDTH-1:0] pos_b_x;
   logic signed [DATA_WIDTH-1:0] pos_b_y;
   logic signed [DATA_WIDTH-1:0] vel_a_x;
   logic signed [DATA_WIDTH-1:0] vel_a_y;
   logic signed [DATA_WIDTH-1:0] vel_b_x;
   logic signed [DATA_WIDTH-1:0] vel_b_y;
   logic        [DATA_WIDTH-2:0] damping_coeff;
   logic                         a_is_mass;
   logic                         b_is_mass;

   modport source (output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y,
                   vel_b_x, vel_b_y, damping_coeff, a_is_mass, b_is_mass, input ready);
   modport sink   (input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y, vel_a_x, vel_a_y,
                   vel_b_x, vel_b_y, damping_coeff, a_is_mass, b_is_mass, output ready);
endinterface

interface sdi_rsp_if #(parameter int DATA_WIDTH = sdi_pkg::DATA_WIDTH_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] new_vel_a_x;
   logic signed [DATA_WIDTH-1:0] new_vel_a_y;
   logic signed [DATA_WIDTH-1:0] new_vel_b_x;
   logic signed [DATA_WIDTH-1:0] new_vel_b_y;
   logic                         skipped;

   modport source (output valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
                   skipped, input ready);
   modport sink   (input valid, new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y,
                   skipped, output ready);
endinterface

interface sdi_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sdi_pkg::MIN_LEN_W-1:0]  min_length;

   modport source (output valid, min_length, input ready);
   modport sink   (input valid, min_length, output ready);
endinterface

### hw/rtl/sdi_front.sv
// ----------------------------------------------------------------------------
// sdi_front
// Input stages: axis and velocity differences, magnitudes, squares, sum.
// ----------------------------------------------------------------------------
module sdi_front #(
   parameter int DATA_WIDTH = sdi_pkg::DATA_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [DATA_WIDTH-1:0]  pos_a_x,
   input  logic signed [DATA_WIDTH-1:0]  pos_a_y,
   input  logic signed [DATA_WIDTH-1:0]  pos_b_x,
   input  logic signed [DATA_WIDTH-1:0]  pos_b_y,
   input  logic signed [DATA_WIDTH-1:0]  vel_a_x,
   input  logic signed [DATA_WIDTH-1:0]  vel_a_y,
   input  logic signed [DATA_WIDTH-1:0]  vel_b_x,
   input  logic signed [DATA_WIDTH-1:0]  vel_b_y,
   input  logic        [DATA_WIDTH-2:0]  damping_coeff,
   input  logic                          a_is_mass,
   input  logic                          b_is_mass,
   output sdi_pkg::stage_ctl_type        ctl_out,
   output logic [2*DATA_WIDTH+2:0]       rad_out,
   output logic [DATA_WIDTH:0]           ax_out,
   output logic [DATA_WIDTH:0]           ay_out,
   output logic                          sx_out,
   output logic                          sy_out,
   output logic [7*DATA_WIDTH:0]         side_out
);
   localparam int W  = DATA_WIDTH;
   localparam int SW = 7 * DATA_WIDTH + 1;

   sdi_pkg::stage_ctl_type ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff, ctl1_in;
   logic signed [W:0]   dx1_ff, dy1_ff, dx1_in, dy1_in, dvx_in, dvy_in;
   logic [SW-1:0]       side1_ff, side2_ff, side3_ff, side4_ff, side1_in;
   logic [W:0]          ax2_ff, ay2_ff, ax3_ff, ay3_ff, ax4_ff, ay4_ff, ax2_in, ay2_in;
   logic                sx2_ff, sy2_ff, sx3_ff, sy3_ff, sx4_ff, sy4_ff;
   logic [2*W+1:0]      x2_ff, y2_ff, x2_in, y2_in;
   logic [2*W+2:0]      rad_ff, rad_in;

   always_comb begin
      ctl1_in.valid  = in_valid;
      ctl1_in.a_mass = a_is_mass;
      ctl1_in.b_mass = b_is_mass;
      ctl1_in.skip   = 1'b0;
      dx1_in = $signed({pos_b_x[W-1], pos_b_x}) - $signed({pos_a_x[W-1], pos_a_x});
      dy1_in = $signed({pos_b_y[W-1], pos_b_y}) - $signed({pos_a_y[W-1], pos_a_y});
      dvx_in = $signed({vel_b_x[W-1], vel_b_x}) - $signed({vel_a_x[W-1], vel_a_x});
      dvy_in = $signed({vel_b_y[W-1], vel_b_y}) - $signed({vel_a_y[W-1], vel_a_y});
      side1_in = {vel_a_x, vel_a_y, vel_b_x, vel_b_y, damping_coeff, dvx_in, dvy_in};
      ax2_in = dx1_ff[W] ? (W+1)'(-dx1_ff) : (W+1)'(dx1_ff);
      ay2_in = dy1_ff[W] ? (W+1)'(-dy1_ff) : (W+1)'(dy1_ff);
      x2_in  = (2*W+2)'(ax2_ff) * (2*W+2)'(ax2_ff);
      y2_in  = (2*W+2)'(ay2_ff) * (2*W+2)'(ay2_ff);
      rad_in = (2*W+3)'(x2_ff) + (2*W+3)'(y2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
      if (adv) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         side1_ff <= side1_in;
         ax2_ff   <= ax2_in;
         ay2_ff   <= ay2_in;
         sx2_ff   <= dx1_ff[W];
         sy2_ff   <= dy1_ff[W];
         side2_ff <= side1_ff;
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         ax3_ff   <= ax2_ff;
         ay3_ff   <= ay2_ff;
         sx3_ff   <= sx2_ff;
         sy3_ff   <= sy2_ff;
         side3_ff <= side2_ff;
         rad_ff   <= rad_in;
         ax4_ff   <= ax3_ff;
         ay4_ff   <= ay3_ff;
         sx4_ff   <= sx3_ff;
         sy4_ff   <= sy3_ff;
         side4_ff <= side3_ff;
      end
   end

   assign ctl_out  = ctl4_ff;
   assign rad_out  = rad_ff;
   assign ax_out   = ax4_ff;
   assign ay_out   = ay4_ff;
   assign sx_out   = sx4_ff;
   assign sy_out   = sy4_ff;
   assign side_out = side4_ff;

endmodule

### hw/rtl/sdi_sqrt.sv
// ----------------------------------------------------------------------------
// sdi_sqrt
// Pipelined floor square root, one root bit per stage, MSB first.
// ----------------------------------------------------------------------------
module sdi_sqrt #(
   parameter int DATA_WIDTH = sdi_pkg::DATA_WIDTH_DEF,
   parameter int CARRY_W    = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  sdi_pkg::stage_ctl_type     ctl_in,
   input  logic [2*DATA_WIDTH+2:0]    rad_in,
   input  logic [CARRY_W-1:0]         carry_in,
   output sdi_pkg::stage_ctl_type     ctl_out,
   output logic [DATA_WIDTH+1:0]      root_out,
   output logic [CARRY_W-1:0]         carry_out
);
   localparam int NS = DATA_WIDTH + 2;      // root bits
   localparam int RW = 2 * DATA_WIDTH + 3;  // radicand bits

   sdi_pkg::stage_ctl_type ctl_ff   [NS];
   logic [RW-1:0]          rem_ff   [NS];
   logic [NS-1:0]          root_ff  [NS];
   logic [CARRY_W-1:0]     carry_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_step
      localparam int B = NS - 1 - k;
      sdi_pkg::stage_ctl_type ctl_prev;
      logic [RW-1:0]          rem_prev, rem_in;
      logic [NS-1:0]          root_prev, root_in;
      logic [CARRY_W-1:0]     carry_prev;
      logic [RW:0]            trial;
      logic                   take;

      if (k == 0) begin : g_first
         assign ctl_prev   = ctl_in;
         assign rem_prev   = rad_in;
         assign root_prev  = '0;
         assign carry_prev = carry_in;
      end else begin : g_next
         assign ctl_prev   = ctl_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign carry_prev = carry_ff[k-1];
      end

      // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
      assign trial   = ((RW+1)'(root_prev) << (B + 1)) | ((RW+1)'(1) << (2 * B));
      assign take    = {1'b0, rem_prev} >= trial;
      assign rem_in  = take ? RW'({1'b0, rem_prev} - trial) : rem_prev;
      assign root_in = take ? (root_prev | (NS'(1) << B)) : root_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (adv) begin
            ctl_ff[k] <= ctl_prev;
         end
         if (adv) begin
            rem_ff[k]   <= rem_in;
            root_ff[k]  <= root_in;
            carry_ff[k] <= carry_prev;
         end
      end
   end

   assign ctl_out   = ctl_ff[NS-1];
   assign root_out  = root_ff[NS-1];
   assign carry_out = carry_ff[NS-1];

endmodule

### hw/rtl/sdi_unit.sv
// ----------------------------------------------------------------------------
// sdi_unit
// Short-spring test and two pipelined dividers forming |d| * 2^F / len.
// ----------------------------------------------------------------------------
module sdi_unit #(
   parameter int DATA_WIDTH = sdi_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = sdi_pkg::FRAC_BITS_DEF,
   parameter int CARRY_W    = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic [sdi_pkg::MIN_LEN_W-1:0]   min_length,
   input  sdi_pkg::stage_ctl_type          ctl_in,
   input  logic [DATA_WIDTH+1:0]           len_in,
   input  logic [DATA_WIDTH:0]             ax_in,
   input  logic [DATA_WIDTH:0]             ay_in,
   input  logic [CARRY_W-1:0]              carry_in,
   output sdi_pkg::stage_ctl_type          ctl_out,
   output logic [FRAC_BITS:0]              qx_out,
   output logic [FRAC_BITS:0]              qy_out,
   output logic [CARRY_W-1:0]              carry_out
);
   localparam int ND = FRAC_BITS + 1;   // quotient bits
   localparam int LW = DATA_WIDTH + 2;  // length bits
   localparam int RW = DATA_WIDTH + 3;  // partial remainder bits

   sdi_pkg::stage_ctl_type ctl_ff   [ND];
   logic [RW-1:0]          rx_ff    [ND];
   logic [RW-1:0]          ry_ff    [ND];
   logic [LW-1:0]          len_ff   [ND];
   logic [ND-1:0]          qx_ff    [ND];
   logic [ND-1:0]          qy_ff    [ND];
   logic [CARRY_W-1:0]     carry_ff [ND];

   for (genvar k = 0; k < ND; k++) begin : g_step
      localparam int B = ND - 1 - k;
      sdi_pkg::stage_ctl_type ctl_prev;
      logic [RW-1:0]          rx_prev, ry_prev, remx, remy, rx_in, ry_in;
      logic [LW-1:0]          len_prev;
      logic [ND-1:0]          qx_prev, qy_prev, qx_in, qy_in;
      logic [CARRY_W-1:0]     carry_prev;
      logic                   takex, takey;

      if (k == 0) begin : g_first
         // |d| <= len, so the first partial remainder is |d| itself
         always_comb begin
            ctl_prev      = ctl_in;
            ctl_prev.skip = (len_in == '0) || (len_in < LW'(min_length));
         end
         assign rx_prev    = RW'(ax_in);
         assign ry_prev    = RW'(ay_in);
         assign len_prev   = len_in;
         assign qx_prev    = '0;
         assign qy_prev    = '0;
         assign carry_prev = carry_in;
      end else begin : g_next
         assign ctl_prev   = ctl_ff[k-1];
         assign rx_prev    = rx_ff[k-1];
         assign ry_prev    = ry_ff[k-1];
         assign len_prev   = len_ff[k-1];
         assign qx_prev    = qx_ff[k-1];
         assign qy_prev    = qy_ff[k-1];
         assign carry_prev = carry_ff[k-1];
      end

      assign takex = rx_prev >= RW'(len_prev);
      assign takey = ry_prev >= RW'(len_prev);
      assign remx  = takex ? (rx_prev - RW'(len_prev)) : rx_prev;
      assign remy  = takey ? (ry_prev - RW'(len_prev)) : ry_prev;
      assign rx_in = {remx[RW-2:0], 1'b0};
      assign ry_in = {remy[RW-2:0], 1'b0};
      assign qx_in = takex ? (qx_prev | (ND'(1) << B)) : qx_prev;
      assign qy_in = takey ? (qy_prev | (ND'(1) << B)) : qy_prev;

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (adv) begin
            ctl_ff[k] <= ctl_prev;
         end
         if (adv) begin
            rx_ff[k]    <= rx_in;
            ry_ff[k]    <= ry_in;
            len_ff[k]   <= len_prev;
            qx_ff[k]    <= qx_in;
            qy_ff[k]    <= qy_in;
            carry_ff[k] <= carry_prev;
         end
      end
   end

   assign ctl_out   = ctl_ff[ND-1];
   assign qx_out    = qx_ff[ND-1];
   assign qy_out    = qy_ff[ND-1];
   assign carry_out = carry_ff[ND-1];

endmodule

### hw/rtl/sdi_impulse.sv
// ----------------------------------------------------------------------------
// sdi_impulse
// Relative velocity, damping impulse and velocity update; ends in the
// result register.
// ----------------------------------------------------------------------------
module sdi_impulse #(
   parameter int DATA_WIDTH = sdi_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = sdi_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  sdi_pkg::stage_ctl_type        ctl_in,
   input  logic [FRAC_BITS:0]            qx_in,
   input  logic [FRAC_BITS:0]            qy_in,
   input  logic                          sx_in,
   input  logic                          sy_in,
   input  logic [7*DATA_WIDTH:0]         side_in,
   output sdi_pkg::stage_ctl_type        ctl_out,
   output logic signed [DATA_WIDTH-1:0]  new_vel_a_x,
   output logic signed [DATA_WIDTH-1:0]  new_vel_a_y,
   output logic signed [DATA_WIDTH-1:0]  new_vel_b_x,
   output logic signed [DATA_WIDTH-1:0]  new_vel_b_y
);
   localparam int W    = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int NW   = F + 2;        // signed unit component
   localparam int DVW  = W + 1;        // velocity difference
   localparam int PW   = DVW + NW;     // dv * n
   localparam int SUMW = PW + 1;
   localparam int PRW  = 2 * W;        // damping * vrel
   localparam int EW   = W + NW;       // impulse * n
   localparam int DW   = W + 2;        // velocity delta
   localparam int XW   = (SUMW > PRW) ? SUMW : PRW;
   localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

   // shift right by F, rounding toward zero
   function automatic logic signed [XW-1:0] shr_trunc(input logic signed [XW-1:0] v);
      logic [XW-1:0] m;
      m = v[XW-1] ? XW'(-v) : XW'(v);
      m = m >> F;
      return v[XW-1] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] t;
      t = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
      return t[W-1:0];
   endfunction

   sdi_pkg::stage_ctl_type   ctl_ff [1:8];
   sdi_pkg::stage_ctl_type   out_ctl_ff;
   logic [4*W-1:0]           vel_ff [1:8];
   logic signed [NW-1:0]     nx_ff  [1:6];
   logic signed [NW-1:0]     ny_ff  [1:6];
   logic [W-2:0]             damp_ff [1:4];
   logic signed [DVW-1:0]    dvx1_ff, dvy1_ff;
   logic signed [PW-1:0]     px2_ff, py2_ff, px2_in, py2_in;
   logic signed [SUMW-1:0]   sum3_ff, sum3_in;
   logic signed [W-1:0]      vrel4_ff, vrel4_in;
   logic signed [PRW-1:0]    prod5_ff, prod5_in;
   logic signed [W-1:0]      imp6_ff, imp6_in;
   logic signed [EW-1:0]     ex7_ff, ey7_ff, ex7_in, ey7_in;
   logic signed [DW-1:0]     ddx8_ff, ddy8_ff, ddx8_in, ddy8_in;
   logic signed [NW-1:0]     nx1_in, ny1_in;
   logic signed [W-1:0]      vax8, vay8, vbx8, vby8;
   logic signed [W-1:0]      nvax_ff, nvay_ff, nvbx_ff, nvby_ff;
   logic signed [W-1:0]      nvax_in, nvay_in, nvbx_in, nvby_in;
   logic                     upd_a, upd_b;

   always_comb begin
      nx1_in   = sx_in ? -$signed({1'b0, qx_in}) : $signed({1'b0, qx_in});
      ny1_in   = sy_in ? -$signed({1'b0, qy_in}) : $signed({1'b0, qy_in});
      px2_in   = dvx1_ff * nx_ff[1];
      py2_in   = dvy1_ff * ny_ff[1];
      sum3_in  = SUMW'(px2_ff) + SUMW'(py2_ff);
      vrel4_in = sat(shr_trunc(XW'(sum3_ff)));
      prod5_in = $signed({1'b0, damp_ff[4]}) * vrel4_ff;
      imp6_in  = sat(shr_trunc(XW'(prod5_ff)));
      ex7_in   = imp6_ff * nx_ff[6];
      ey7_in   = imp6_ff * ny_ff[6];
      ddx8_in  = DW'(shr_trunc(XW'(ex7_ff)));
      ddy8_in  = DW'(shr_trunc(XW'(ey7_ff)));
      {vax8, vay8, vbx8, vby8} = vel_ff[8];
      upd_a    = ctl_ff[8].a_mass && !ctl_ff[8].skip;
      upd_b    = ctl_ff[8].b_mass && !ctl_ff[8].skip;
      nvax_in  = upd_a ? sat(XW'(vax8) + XW'(ddx8_ff)) : vax8;
      nvay_in  = upd_a ? sat(XW'(vay8) + XW'(ddy8_ff)) : vay8;
      nvbx_in  = upd_b ? sat(XW'(vbx8) - XW'(ddx8_ff)) : vbx8;
      nvby_in  = upd_b ? sat(XW'(vby8) - XW'(ddy8_ff)) : vby8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 8; i++) begin
            ctl_ff[i] <= '0;
         end
         out_ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff[1] <= ctl_in;
         for (int i = 2; i <= 8; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
         out_ctl_ff <= ctl_ff[8];
      end
      if (adv) begin
         vel_ff[1]  <= side_in[7*W:3*W+1];
         damp_ff[1] <= side_in[3*W:2*W+2];
         dvx1_ff    <= $signed(side_in[2*W+1:W+1]);
         dvy1_ff    <= $signed(side_in[W:0]);
         nx_ff[1]   <= nx1_in;
         ny_ff[1]   <= ny1_in;
         for (int i = 2; i <= 8; i++) begin
            vel_ff[i] <= vel_ff[i-1];
         end
         for (int i = 2; i <= 6; i++) begin
            nx_ff[i] <= nx_ff[i-1];
            ny_ff[i] <= ny_ff[i-1];
         end
         for (int i = 2; i <= 4; i++) begin
            damp_ff[i] <= damp_ff[i-1];
         end
         px2_ff   <= px2_in;
         py2_ff   <= py2_in;
         sum3_ff  <= sum3_in;
         vrel4_ff <= vrel4_in;
         prod5_ff <= prod5_in;
         imp6_ff  <= imp6_in;
         ex7_ff   <= ex7_in;
         ey7_ff   <= ey7_in;
         ddx8_ff  <= ddx8_in;
         ddy8_ff  <= ddy8_in;
         nvax_ff  <= nvax_in;
         nvay_ff  <= nvay_in;
         nvbx_ff  <= nvbx_in;
         nvby_ff  <= nvby_in;
      end
   end

   assign ctl_out     = out_ctl_ff;
   assign new_vel_a_x = nvax_ff;
   assign new_vel_a_y = nvay_ff;
   assign new_vel_b_x = nvbx_ff;
   assign new_vel_b_y = nvby_ff;

   // a skipped item leaves with its input velocities
   a_skip_pass: assert property (@(posedge clock) disable iff (reset)
      (adv && ctl_ff[8].valid && ctl_ff[8].skip) |=>
      (nvax_ff == $past(vel_ff[8][4*W-1:3*W]) && nvay_ff == $past(vel_ff[8][3*W-1:2*W]) &&
       nvbx_ff == $past(vel_ff[8][2*W-1:W])   && nvby_ff == $past(vel_ff[8][W-1:0])))
      else $error("skipped item changed a velocity");

   // a fixed end B is never updated
   a_fixed_b: assert property (@(posedge clock) disable iff (reset)
      (adv && ctl_ff[8].valid && !ctl_ff[8].b_mass) |=>
      (nvbx_ff == $past(vel_ff[8][2*W-1:W]) && nvby_ff == $past(vel_ff[8][W-1:0])))
      else $error("fixed end B velocity changed");

   // result register holds while stalled
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(out_ctl_ff) && $stable(nvax_ff) && $stable(nvby_ff)))
      else $error("result register changed during stall");

endmodule

### hw/rtl/spring_damping_impulse_top.sv
// Stages from request to result: 4 input stages, one sqrt stage per root bit,
// one divide stage per quotient bit, 8 impulse stages and the result register.
// Throughput: one item per cycle; the whole pipeline holds while a result is not taken.
// Reset clears all stage valid bits and sets min_length to 1.
// ----------------------------------------------------------------------------
// spring_damping_impulse_top
// Damping impulse along a spring axis applied to the velocities of its two ends.
// ----------------------------------------------------------------------------
module spring_damping_impulse_top #(
   parameter int DATA_WIDTH = sdi_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = sdi_pkg::FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sdi_req_if.sink       req_chan,
   sdi_rsp_if.source     rsp_chan,
   sdi_csr_if.sink       csr_chan
);
   localparam int W      = DATA_WIDTH;
   localparam int SIDE_W = 7 * W + 1;
   localparam int UN_CW  = 2 + SIDE_W;
   localparam int SQ_CW  = 2 * (W + 1) + UN_CW;

   logic [sdi_pkg::MIN_LEN_W-1:0] min_length_ff;
   logic                          adv;

   sdi_pkg::stage_ctl_type fr_ctl, sq_ctl, un_ctl, im_ctl;
   logic [2*W+2:0]         fr_rad;
   logic [W:0]             fr_ax, fr_ay;
   logic                   fr_sx, fr_sy;
   logic [SIDE_W-1:0]      fr_side;
   logic [W+1:0]           sq_root;
   logic [SQ_CW-1:0]       sq_carry;
   logic [FRAC_BITS:0]     un_qx, un_qy;
   logic [UN_CW-1:0]       un_carry;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= sdi_pkg::MIN_LEN_RST;
      end else if (csr_chan.valid) begin
         min_length_ff <= csr_chan.min_length;
      end
   end

   assign csr_chan.ready = 1'b1;
   assign adv            = !im_ctl.valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   sdi_front #(.DATA_WIDTH(W)) u_front (
      .clock, .reset, .adv,
      .in_valid      (req_chan.valid),
      .pos_a_x       (req_chan.pos_a_x),
      .pos_a_y       (req_chan.pos_a_y),
      .pos_b_x       (req_chan.pos_b_x),
      .pos_b_y       (req_chan.pos_b_y),
      .vel_a_x       (req_chan.vel_a_x),
      .vel_a_y       (req_chan.vel_a_y),
      .vel_b_x       (req_chan.vel_b_x),
      .vel_b_y       (req_chan.vel_b_y),
      .damping_coeff (req_chan.damping_coeff),
      .a_is_mass     (req_chan.a_is_mass),
      .b_is_mass     (req_chan.b_is_mass),
      .ctl_out       (fr_ctl),
      .rad_out       (fr_rad),
      .ax_out        (fr_ax),
      .ay_out        (fr_ay),
      .sx_out        (fr_sx),
      .sy_out        (fr_sy),
      .side_out      (fr_side)
   );

   sdi_sqrt #(.DATA_WIDTH(W), .CARRY_W(SQ_CW)) u_sqrt (
      .clock, .reset, .adv,
      .ctl_in    (fr_ctl),
      .rad_in    (fr_rad),
      .carry_in  ({fr_ax, fr_ay, fr_sx, fr_sy, fr_side}),
      .ctl_out   (sq_ctl),
      .root_out  (sq_root),
      .carry_out (sq_carry)
   );

   sdi_unit #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS), .CARRY_W(UN_CW)) u_unit (
      .clock, .reset, .adv,
      .min_length (min_length_ff),
      .ctl_in     (sq_ctl),
      .len_in     (sq_root),
      .ax_in      (sq_carry[SQ_CW-1:SQ_CW-W-1]),
      .ay_in      (sq_carry[SQ_CW-W-2:SQ_CW-2*W-2]),
      .carry_in   (sq_carry[UN_CW-1:0]),
      .ctl_out    (un_ctl),
      .qx_out     (un_qx),
      .qy_out     (un_qy),
      .carry_out  (un_carry)
   );

   sdi_impulse #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_impulse (
      .clock, .reset, .adv,
      .ctl_in      (un_ctl),
      .qx_in       (un_qx),
      .qy_in       (un_qy),
      .sx_in       (un_carry[UN_CW-1]),
      .sy_in       (un_carry[UN_CW-2]),
      .side_in     (un_carry[SIDE_W-1:0]),
      .ctl_out     (im_ctl),
      .new_vel_a_x (rsp_chan.new_vel_a_x),
      .new_vel_a_y (rsp_chan.new_vel_a_y),
      .new_vel_b_x (rsp_chan.new_vel_b_x),
      .new_vel_b_y (rsp_chan.new_vel_b_y)
   );

   assign rsp_chan.valid   = im_ctl.valid;
   assign rsp_chan.skipped = im_ctl.skip;

endmodule
